### rtl/core/epdc_pkg.sv
// Package with shared types, constants and tables for the date-time converter.
`timescale 1ns / 1ps
`default_nettype none

package epdc_pkg;

    // Overall latency from an accepted request to its result strobe.
    localparam int EPDC_LAT = 17;

    // Constant divider: reciprocal multiply, quotient, remainder, correction.
    localparam int DIV_STAGES = 4;
    localparam logic [19:0] DIV_DAY = 20'd86400;
    localparam logic [19:0] DIV_BCD = 20'd1000000;

    // Truncated reciprocals floor(2^47 / D); the quotient they give is at most one short.
    localparam logic [30:0] REC_DAY = 31'((64'd1 << 47) / 64'd86400);
    localparam logic [30:0] REC_BCD = 31'((64'd1 << 47) / 64'd1000000);

    // Reciprocals for exact division by constants: floor(2^K / D) + 1.
    localparam logic [17:0] MUL_3600   = 18'((64'd1 << 29) / 64'd3600 + 64'd1);
    localparam logic [17:0] MUL_60     = 18'((64'd1 << 23) / 64'd60 + 64'd1);
    localparam logic [31:0] MUL_ERA    = 32'((64'd1 << 49) / 64'd146097 + 64'd1);
    localparam logic [18:0] MUL_1460   = 19'((64'd1 << 29) / 64'd1460 + 64'd1);
    localparam logic [18:0] MUL_36524  = 19'((64'd1 << 34) / 64'd36524 + 64'd1);
    localparam logic [18:0] MUL_365    = 19'((64'd1 << 27) / 64'd365 + 64'd1);
    localparam logic [9:0]  MUL_100_9  = 10'((64'd1 << 16) / 64'd100 + 64'd1);
    localparam logic [11:0] MUL_153    = 12'((64'd1 << 19) / 64'd153 + 64'd1);
    localparam logic [11:0] MUL_5      = 12'((64'd1 << 14) / 64'd5 + 64'd1);
    localparam logic [20:0] MUL_100_20 = 21'((64'd1 << 27) / 64'd100 + 64'd1);
    localparam logic [20:0] MUL_1E4_20 = 21'((64'd1 << 34) / 64'd10000 + 64'd1);
    localparam logic [28:0] MUL_100_28 = 29'((64'd1 << 35) / 64'd100 + 64'd1);
    localparam logic [21:0] MUL_100_21 = 22'((64'd1 << 28) / 64'd100 + 64'd1);

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_SEC,
        ERR_MIN,
        ERR_HOUR,
        ERR_DAY,
        ERR_MON,
        ERR_YEAR
    } epdc_err_t;

    typedef struct packed {
        logic func;
        logic zero;
    } epdc_tag_t;

    typedef struct packed {
        logic [4:0] hr;
        logic [5:0] mn;
        logic [5:0] sc;
    } epdc_hms_t;

    typedef struct packed {
        logic [46:0] res;
        epdc_err_t   err;
    } epdc_res_t;

    // Days before the start of a month, counting from March.
    function automatic logic [8:0] epdc_mp_days(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/core/epdc_div.sv
// Four-stage divider by 86400 or 1000000 using a reciprocal multiply and one correction.
`timescale 1ns / 1ps
`default_nettype none

module epdc_div
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_vld,
    input  wire epdc_pkg::epdc_tag_t in_tag,
    input  wire [46:0]             in_value,
    output logic                   out_vld,
    output epdc_pkg::epdc_tag_t    out_tag,
    output logic [31:0]            quot,
    output logic [19:0]            rem
);
    import epdc_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;

    epdc_tag_t   s1_tag_reg;
    logic [54:0] s1_lo_reg, s1_lo_next;
    logic [53:0] s1_hi_reg, s1_hi_next;
    logic [20:0] s1_x_reg;

    epdc_tag_t   s2_tag_reg;
    logic [30:0] s2_q_reg, s2_q_next;
    logic [20:0] s2_x_reg;

    epdc_tag_t   s3_tag_reg;
    logic [30:0] s3_q_reg;
    logic [20:0] s3_r_reg, s3_r_next;

    epdc_tag_t   s4_tag_reg;
    logic [31:0] s4_q_reg, s4_q_next;
    logic [19:0] s4_r_reg, s4_r_next;

    always_comb
    begin
        logic [30:0] rc;
        logic [77:0] sum;
        logic [19:0] dv3;
        logic [19:0] dv4;
        logic [50:0] qd;

        // The 47-bit dividend is multiplied in two halves to keep each product narrow.
        rc         = in_tag.func ? REC_BCD : REC_DAY;
        s1_lo_next = in_value[23:0] * rc;
        s1_hi_next = in_value[46:24] * rc;

        sum       = {s1_hi_reg, 24'd0} + {23'd0, s1_lo_reg};
        s2_q_next = sum[77:47];

        // The estimate is at most one short, so the remainder fits in 21 bits.
        dv3       = s2_tag_reg.func ? DIV_BCD : DIV_DAY;
        qd        = s2_q_reg * dv3;
        s3_r_next = s2_x_reg - qd[20:0];

        dv4 = s3_tag_reg.func ? DIV_BCD : DIV_DAY;
        if (s3_r_reg >= {1'b0, dv4})
        begin
            s4_q_next = {1'b0, s3_q_reg} + 32'd1;
            s4_r_next = 20'(s3_r_reg - {1'b0, dv4});
        end
        else
        begin
            s4_q_next = {1'b0, s3_q_reg};
            s4_r_next = s3_r_reg[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= in_tag;
        s1_lo_reg  <= s1_lo_next;
        s1_hi_reg  <= s1_hi_next;
        s1_x_reg   <= in_value[20:0];

        s2_tag_reg <= s1_tag_reg;
        s2_q_reg   <= s2_q_next;
        s2_x_reg   <= s1_x_reg;

        s3_tag_reg <= s2_tag_reg;
        s3_q_reg   <= s2_q_reg;
        s3_r_reg   <= s3_r_next;

        s4_tag_reg <= s3_tag_reg;
        s4_q_reg   <= s4_q_next;
        s4_r_reg   <= s4_r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[DIV_STAGES-1];
    assign out_tag = s4_tag_reg;
    assign quot    = s4_q_reg;
    assign rem     = s4_r_reg;

endmodule

`default_nettype wire

### rtl/core/epoch_packed_datetime_convert_unit.sv
// Top level of the epoch / packed decimal date-time converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts UTC seconds since 1970 to packed YYYYMMDDhhmmss (func 0) or back
// (func 1). The unit takes one request every clock cycle and busy stays low.
// Each result appears on done after one input register, four stages of the
// divider by 86400 or 1000000 (reciprocal multiply with one correction),
// eleven stages that walk the civil calendar arithmetic and one output
// register. The receiver cannot stall the unit, so results must be taken in
// the cycle they are strobed.

module epoch_packed_datetime_convert_unit
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         func,
    input  wire  [46:0] value,
    output logic        done,
    output logic [46:0] result_value,
    output logic [2:0]  error_code
);
    import epdc_pkg::*;

    // Input register.
    logic        in_vld_reg;
    epdc_tag_t   in_tag_reg;
    logic [46:0] in_val_reg;

    // Divider outputs.
    logic        d_vld;
    epdc_tag_t   d_tag;
    logic [31:0] d_quot;
    logic [19:0] d_rem;

    // Valid and tag lines for the eleven stages after the divider.
    logic [10:0] pv_reg;
    epdc_tag_t   pt_reg [11];

    // Epoch to packed path.
    logic [30:0] a1_z_reg,  a1_z_next;
    logic [4:0]  a1_hr_reg, a1_hr_next;
    logic [10:0] a1_mq_reg, a1_mq_next;
    logic [16:0] a1_sod_reg;
    logic [13:0] a2_era_reg, a2_era_next;
    logic [30:0] a2_z_reg;
    epdc_hms_t   a2_hms_next;
    epdc_hms_t   a_hms_reg [9];
    logic [17:0] a3_doe_reg, a3_doe_next;
    logic [13:0] a3_era_reg;
    logic [6:0]  a4_t1_reg, a4_t1_next;
    logic [2:0]  a4_t2_reg, a4_t2_next;
    logic        a4_t3_reg;
    logic [17:0] a4_doe_reg;
    logic [13:0] a4_era_reg;
    logic [17:0] a5_num_reg, a5_doe_reg;
    logic [13:0] a5_era_reg;
    logic [8:0]  a6_yoe_reg, a6_yoe_next;
    logic [17:0] a6_doe_reg;
    logic [13:0] a6_era_reg;
    logic [17:0] a7_y365_reg, a7_y365_next;
    logic [2:0]  a7_yc_reg,   a7_yc_next;
    logic [8:0]  a7_yoe_reg;
    logic [22:0] a7_yb_reg,   a7_yb_next;
    logic [17:0] a7_doe_reg;
    logic [8:0]  a8_doy_reg,  a8_doy_next;
    logic [22:0] a8_yb_reg;
    logic [3:0]  a9_mp_reg,   a9_mp_next;
    logic [8:0]  a9_doy_reg;
    logic [22:0] a9_yb_reg;
    logic [4:0]  a10_d_reg,   a10_d_next;
    logic [3:0]  a10_m_reg,   a10_m_next;
    logic [22:0] a10_y_reg,   a10_y_next;
    logic        a11_big_reg, a11_big_next;
    logic [33:0] a11_lo_reg,  a11_lo_next;
    logic [13:0] a11_y_reg;

    // Packed to epoch path.
    logic [27:0] b1_ymd_reg;
    logic [19:0] b1_hms_reg;
    logic [20:0] b1_ym_reg, b1_ym_next;
    logic [13:0] b1_hm_reg, b1_hm_next;
    logic [6:0]  b1_hh_reg, b1_hh_next;
    logic [6:0]  b2_day_reg, b2_day_next;
    logic [6:0]  b2_ss_reg,  b2_ss_next;
    logic [6:0]  b2_mm_reg,  b2_mm_next;
    logic [6:0]  b2_hh_reg;
    logic [14:0] b2_yr_reg,  b2_yr_next;
    logic [20:0] b2_ym_reg;
    logic [6:0]  b3_mon_reg, b3_mon_next;
    epdc_err_t   b3_err_reg, b3_err_next;
    logic [6:0]  b3_day_reg, b3_ss_reg, b3_mm_reg, b3_hh_reg;
    logic [14:0] b3_yr_reg;
    logic [8:0]  b4_yoe_reg,  b4_yoe_next;
    logic [8:0]  b4_doy_reg,  b4_doy_next;
    logic [16:0] b4_hsec_reg, b4_hsec_next;
    epdc_err_t   b4_err_reg;
    logic [15:0] b5_days_reg, b5_days_next;
    logic [16:0] b5_hsec_reg;
    epdc_err_t   b5_err_reg;
    epdc_res_t   b6_res_next;
    epdc_res_t   b_line_reg [6];

    // Output registers.
    logic        done_reg;
    logic [46:0] res_reg, res_next;
    epdc_err_t   err_reg, err_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            pv_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start & ~busy;
            pv_reg     <= {pv_reg[9:0], d_vld};
            done_reg   <= pv_reg[10];
        end
    end

    always_ff @(posedge clk)
    begin
        in_tag_reg.func <= func;
        in_tag_reg.zero <= (value == 47'd0);
        in_val_reg      <= value;
    end

    epdc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld_reg),
        .in_tag   (in_tag_reg),
        .in_value (in_val_reg),
        .out_vld  (d_vld),
        .out_tag  (d_tag),
        .quot     (d_quot),
        .rem      (d_rem)
    );

    // ---------------- Epoch to packed ----------------
    always_comb
    begin
        logic [34:0] ph;
        logic [34:0] pm;
        logic [62:0] pe;
        logic [16:0] t17;
        logic [10:0] t11;
        logic [30:0] t31;
        logic [36:0] p1460;
        logic [36:0] p36524;
        logic [36:0] p365;
        logic [18:0] p100;
        logic [17:0] t18;
        logic [10:0] n11;
        logic [22:0] p23;
        logic [8:0]  q9;
        logic [8:0]  d9;

        // Stage 1: shift to the March-based day count, split the second of day.
        a1_z_next  = d_quot[30:0] + 31'd719468;
        ph         = d_rem[16:0] * MUL_3600;
        pm         = d_rem[16:0] * MUL_60;
        a1_hr_next = ph[33:29];
        a1_mq_next = pm[33:23];

        // Stage 2: era of 400 years, minutes and seconds.
        pe          = a1_z_reg * MUL_ERA;
        a2_era_next = pe[62:49];
        t17         = a1_mq_reg * 17'd60;
        t11         = a1_hr_reg * 11'd60;
        a2_hms_next.hr = a1_hr_reg;
        a2_hms_next.sc = 6'(a1_sod_reg - t17);
        a2_hms_next.mn = 6'(a1_mq_reg - t11);

        // Stage 3: day of era.
        t31         = a2_era_reg * 31'd146097;
        a3_doe_next = 18'(a2_z_reg - t31);

        // Stage 4: leap corrections.
        p1460      = a3_doe_reg * MUL_1460;
        p36524     = a3_doe_reg * MUL_36524;
        a4_t1_next = p1460[35:29];
        a4_t2_next = p36524[36:34];

        // Stage 6: year of era.
        p365        = a5_num_reg * MUL_365;
        a6_yoe_next = p365[35:27];

        // Stage 7.
        a7_y365_next = a6_yoe_reg * 18'd365;
        p100         = a6_yoe_reg * MUL_100_9;
        a7_yc_next   = p100[18:16];
        a7_yb_next   = a6_yoe_reg + a6_era_reg * 23'd400;

        // Stage 8: day of year.
        t18         = a7_y365_reg + (a7_yoe_reg >> 2) - a7_yc_reg;
        a8_doy_next = 9'(a7_doe_reg - t18);

        // Stage 9: month index from March.
        n11        = a8_doy_reg * 11'd5 + 11'd2;
        p23        = n11 * MUL_153;
        a9_mp_next = p23[22:19];

        // Stage 10: day of month, month, year.
        n11        = a9_mp_reg * 11'd153 + 11'd2;
        p23        = n11 * MUL_5;
        q9         = p23[22:14];
        d9         = a9_doy_reg - q9 + 9'd1;
        a10_d_next = d9[4:0];
        a10_m_next = (a9_mp_reg < 4'd10) ? a9_mp_reg + 4'd3 : a9_mp_reg - 4'd9;
        a10_y_next = a9_yb_reg + ((a10_m_next <= 4'd2) ? 23'd1 : 23'd0);

        // Stage 11: decimal packing of everything below the year.
        a11_big_next = (a10_y_reg > 23'd9999);
        a11_lo_next  = a10_m_reg * 34'd100000000 + a10_d_reg * 34'd1000000
                     + a_hms_reg[8].hr * 34'd10000 + a_hms_reg[8].mn * 34'd100
                     + a_hms_reg[8].sc;
    end

    always_ff @(posedge clk)
    begin
        a1_z_reg   <= a1_z_next;
        a1_hr_reg  <= a1_hr_next;
        a1_mq_reg  <= a1_mq_next;
        a1_sod_reg <= d_rem[16:0];

        a2_era_reg   <= a2_era_next;
        a2_z_reg     <= a1_z_reg;
        a_hms_reg[0] <= a2_hms_next;
        for (int i = 1; i < 9; i++)
        begin
            a_hms_reg[i] <= a_hms_reg[i-1];
        end

        a3_doe_reg <= a3_doe_next;
        a3_era_reg <= a2_era_reg;

        a4_t1_reg  <= a4_t1_next;
        a4_t2_reg  <= a4_t2_next;
        a4_t3_reg  <= (a3_doe_reg == 18'd146096);
        a4_doe_reg <= a3_doe_reg;
        a4_era_reg <= a3_era_reg;

        a5_num_reg <= a4_doe_reg - a4_t1_reg + a4_t2_reg - a4_t3_reg;
        a5_doe_reg <= a4_doe_reg;
        a5_era_reg <= a4_era_reg;

        a6_yoe_reg <= a6_yoe_next;
        a6_doe_reg <= a5_doe_reg;
        a6_era_reg <= a5_era_reg;

        a7_y365_reg <= a7_y365_next;
        a7_yc_reg   <= a7_yc_next;
        a7_yoe_reg  <= a6_yoe_reg;
        a7_yb_reg   <= a7_yb_next;
        a7_doe_reg  <= a6_doe_reg;

        a8_doy_reg <= a8_doy_next;
        a8_yb_reg  <= a7_yb_reg;

        a9_mp_reg  <= a9_mp_next;
        a9_doy_reg <= a8_doy_reg;
        a9_yb_reg  <= a8_yb_reg;

        a10_d_reg <= a10_d_next;
        a10_m_reg <= a10_m_next;
        a10_y_reg <= a10_y_next;

        a11_big_reg <= a11_big_next;
        a11_lo_reg  <= a11_lo_next;
        a11_y_reg   <= a10_y_reg[13:0];
    end

    // ---------------- Packed to epoch ----------------
    always_comb
    begin
        logic [40:0] phm;
        logic [40:0] phh;
        logic [56:0] pym;
        logic [42:0] pyr;
        logic [27:0] t28;
        logic [19:0] t20;
        logic [13:0] t14;
        logic [20:0] t21;
        logic [14:0] yy;
        logic [3:0]  mp;
        logic [2:0]  yc;
        logic [17:0] doe;
        logic [32:0] pr;

        // Stage 1: split off the two-digit groups by reciprocal multiplies.
        phm        = d_rem * MUL_100_20;
        phh        = d_rem * MUL_1E4_20;
        pym        = d_quot[27:0] * MUL_100_28;
        b1_hm_next = phm[40:27];
        b1_hh_next = phh[40:34];
        b1_ym_next = pym[55:35];

        // Stage 2.
        t28         = b1_ym_reg * 28'd100;
        t20         = b1_hm_reg * 20'd100;
        t14         = b1_hh_reg * 14'd100;
        b2_day_next = 7'(b1_ymd_reg - t28);
        b2_ss_next  = 7'(b1_hms_reg - t20);
        b2_mm_next  = 7'(b1_hm_reg - t14);
        pyr         = b1_ym_reg * MUL_100_21;
        b2_yr_next  = pyr[42:28];

        // Stage 3: month and the field checks in their fixed order.
        t21         = b2_yr_reg * 21'd100;
        b3_mon_next = 7'(b2_ym_reg - t21);
        if (b2_ss_reg > 7'd59)
        begin
            b3_err_next = ERR_SEC;
        end
        else if (b2_mm_reg > 7'd59)
        begin
            b3_err_next = ERR_MIN;
        end
        else if (b2_hh_reg > 7'd23)
        begin
            b3_err_next = ERR_HOUR;
        end
        else if (b2_day_reg < 7'd1 || b2_day_reg > 7'd31)
        begin
            b3_err_next = ERR_DAY;
        end
        else if (b3_mon_next < 7'd1 || b3_mon_next > 7'd12)
        begin
            b3_err_next = ERR_MON;
        end
        else if (b2_yr_reg < 15'd2000 || b2_yr_reg > 15'd2100)
        begin
            b3_err_next = ERR_YEAR;
        end
        else
        begin
            b3_err_next = ERR_NONE;
        end

        // Stage 4: years of era are counted from 1600 for all valid years.
        yy           = (b3_mon_reg <= 7'd2) ? b3_yr_reg - 15'd1 : b3_yr_reg;
        b4_yoe_next  = 9'(yy - 15'd1600);
        mp           = (b3_mon_reg > 7'd2) ? 4'(b3_mon_reg - 7'd3) : 4'(b3_mon_reg + 7'd9);
        b4_doy_next  = epdc_mp_days(mp) + b3_day_reg - 9'd1;
        b4_hsec_next = b3_hh_reg * 17'd3600 + b3_mm_reg * 17'd60 + b3_ss_reg;

        // Stage 5: days since 1970. Century years drop a day unless divisible by 400.
        if (b4_yoe_reg >= 9'd500)
        begin
            yc = 3'd4;
        end
        else
        begin
            yc = 3'd3;
        end
        doe          = b4_yoe_reg * 18'd365 + (b4_yoe_reg >> 2) + b4_doy_reg - yc;
        b5_days_next = 16'(doe - 18'd135080);

        // Stage 6.
        pr              = b5_days_reg * 17'd86400 + b5_hsec_reg;
        b6_res_next.err = b5_err_reg;
        b6_res_next.res = (b5_err_reg == ERR_NONE) ? 47'(pr) : 47'd0;
    end

    always_ff @(posedge clk)
    begin
        b1_ymd_reg <= d_quot[27:0];
        b1_hms_reg <= d_rem;
        b1_ym_reg  <= b1_ym_next;
        b1_hm_reg  <= b1_hm_next;
        b1_hh_reg  <= b1_hh_next;

        b2_day_reg <= b2_day_next;
        b2_ss_reg  <= b2_ss_next;
        b2_mm_reg  <= b2_mm_next;
        b2_hh_reg  <= b1_hh_reg;
        b2_yr_reg  <= b2_yr_next;
        b2_ym_reg  <= b1_ym_reg;

        b3_mon_reg <= b3_mon_next;
        b3_err_reg <= b3_err_next;
        b3_day_reg <= b2_day_reg;
        b3_ss_reg  <= b2_ss_reg;
        b3_mm_reg  <= b2_mm_reg;
        b3_hh_reg  <= b2_hh_reg;
        b3_yr_reg  <= b2_yr_reg;

        b4_yoe_reg  <= b4_yoe_next;
        b4_doy_reg  <= b4_doy_next;
        b4_hsec_reg <= b4_hsec_next;
        b4_err_reg  <= b3_err_reg;

        b5_days_reg <= b5_days_next;
        b5_hsec_reg <= b4_hsec_reg;
        b5_err_reg  <= b4_err_reg;

        // The reverse result waits here until the forward path catches up.
        b_line_reg[0] <= b6_res_next;
        for (int i = 1; i < 6; i++)
        begin
            b_line_reg[i] <= b_line_reg[i-1];
        end

        pt_reg[0] <= d_tag;
        for (int i = 1; i < 11; i++)
        begin
            pt_reg[i] <= pt_reg[i-1];
        end

        res_reg <= res_next;
        err_reg <= err_next;
    end

    // ---------------- Result select ----------------
    always_comb
    begin
        logic [47:0] hi;
        hi = a11_y_reg * 48'd10000000000 + a11_lo_reg;
        if (pt_reg[10].zero)
        begin
            res_next = 47'd0;
            err_next = ERR_NONE;
        end
        else if (pt_reg[10].func)
        begin
            res_next = b_line_reg[5].res;
            err_next = b_line_reg[5].err;
        end
        else if (a11_big_reg)
        begin
            res_next = 47'd0;
            err_next = ERR_YEAR;
        end
        else
        begin
            res_next = hi[46:0];
            err_next = ERR_NONE;
        end
    end

    assign done         = done_reg;
    assign result_value = res_reg;
    assign error_code   = err_reg;

endmodule

`default_nettype wire

### rtl/core/epdc_chk.sv
// Port-level assertions for the date-time converter, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module epdc_chk
(
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire [46:0] result_value,
    input wire [2:0]  error_code
);
    import epdc_pkg::*;

    // Every accepted request yields its result after the fixed latency.
    a_req_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##EPDC_LAT done)
        else $error("request without result");

    // No result is shown that no request caused.
    a_done_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, EPDC_LAT))
        else $error("result without request");

    // An error result carries a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_code != ERR_NONE) |-> (result_value == 47'd0))
        else $error("error result with nonzero value");

    // Error codes stay within the defined set.
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (error_code <= ERR_YEAR))
        else $error("undefined error code");

endmodule

bind epoch_packed_datetime_convert_unit epdc_chk u_epdc_chk (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the epoch / packed date-time converter.
`timescale 1ns / 1ps

module tb_top;
    import epdc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [46:0] value;
    logic        done;
    logic [46:0] result_value;
    logic [2:0]  error_code;

    typedef struct {
        logic [46:0] res;
        epdc_err_t   err;
    } conv_result_t;

    conv_result_t pending_q[$];
    int           fail_count;
    int           burst_left;

    localparam logic [63:0] SECS_DAY = 64'd86400;
    localparam logic [63:0] SHIFT_DAYS = 64'd719468;
    localparam logic [63:0] ERA_DAYS = 64'd146097;

    epoch_packed_datetime_convert_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .error_code   (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [63:0] civil_days(input logic [63:0] y, input logic [63:0] m,
                                               input logic [63:0] d);
        logic [63:0] yy;
        logic [63:0] era;
        logic [63:0] yoe;
        logic [63:0] mp;
        logic [63:0] doy;
        logic [63:0] doe;
        yy  = (m <= 2) ? y - 1 : y;
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * ERA_DAYS + doe - SHIFT_DAYS;
    endfunction

    function automatic conv_result_t convert_datetime(input logic f, input logic [46:0] v);
        conv_result_t r;
        logic [63:0] t;
        logic [63:0] days;
        logic [63:0] sod;
        logic [63:0] z;
        logic [63:0] era;
        logic [63:0] doe;
        logic [63:0] yoe;
        logic [63:0] y;
        logic [63:0] doy;
        logic [63:0] mp;
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] sc;
        logic [63:0] mn;
        logic [63:0] hr;
        r.res = '0;
        r.err = ERR_NONE;
        t = 64'(v);
        if (t == 0)
            return r;
        if (!f)
        begin
            days = t / SECS_DAY;
            sod  = t % SECS_DAY;
            z    = days + SHIFT_DAYS;
            era  = z / ERA_DAYS;
            doe  = z - era * ERA_DAYS;
            yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            y    = yoe + era * 400;
            doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp   = (5 * doy + 2) / 153;
            d    = doy - (153 * mp + 2) / 5 + 1;
            m    = (mp < 10) ? mp + 3 : mp - 9;
            if (m <= 2)
                y = y + 1;
            if (y > 9999)
                r.err = ERR_YEAR;
            else
                r.res = 47'(((((y * 100 + m) * 100 + d) * 100 + sod / 3600) * 100
                             + (sod / 60) % 60) * 100 + sod % 60);
            return r;
        end
        sc = t % 100;  t = t / 100;
        mn = t % 100;  t = t / 100;
        hr = t % 100;  t = t / 100;
        d  = t % 100;  t = t / 100;
        m  = t % 100;  y = t / 100;
        if (sc > 59)
            r.err = ERR_SEC;
        else if (mn > 59)
            r.err = ERR_MIN;
        else if (hr > 23)
            r.err = ERR_HOUR;
        else if (d < 1 || d > 31)
            r.err = ERR_DAY;
        else if (m < 1 || m > 12)
            r.err = ERR_MON;
        else if (y < 2000 || y > 2100)
            r.err = ERR_YEAR;
        else
            r.res = 47'(civil_days(y, m, d) * SECS_DAY + hr * 3600 + mn * 60 + sc);
        return r;
    endfunction

    function automatic logic [46:0] pack_datetime(input int y, input int mo, input int d,
                                                  input int h, input int mi, input int s);
        return 47'(((((64'(y) * 100 + mo) * 100 + d) * 100 + h) * 100 + mi) * 100 + s);
    endfunction

    // Drives one request at the falling edge and holds it until accepted.
    // Gaps between bursts are inserted here so start never drops mid-burst.
    task automatic send_request(input logic f, input logic [46:0] v);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(0, 4) * ($urandom_range(0, 2) == 0)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        start <= 1'b1;
        func  <= f;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_q.push_back(convert_datetime(f, v));
        burst_left--;
        @(negedge clk);
    endtask

    task automatic idle_line();
        start <= 1'b0;
        burst_left = 0;
    endtask

    always @(posedge clk)
    begin
        conv_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with no request outstanding: %0d / %0d",
                       result_value, error_code);
                fail_count++;
            end
            else
            begin
                exp_r = pending_q.pop_front();
                if (result_value !== exp_r.res)
                begin
                    $error("result_value expected %0d actual %0d", exp_r.res, result_value);
                    fail_count++;
                end
                if (error_code !== exp_r.err)
                begin
                    $error("error_code expected %0d actual %0d", exp_r.err, error_code);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_zero_and_extremes();
        send_request(1'b0, '0);
        send_request(1'b1, '0);
        send_request(1'b0, 47'd1);
        send_request(1'b0, '1);
        send_request(1'b1, '1);
        send_request(1'b0, 47'd253402300799);
        send_request(1'b0, 47'd253402300800);
        send_request(1'b1, 47'd99999999999999);
        idle_line();
    endtask

    task automatic test_field_errors();
        send_request(1'b1, pack_datetime(2020, 5, 5, 5, 5, 60));
        send_request(1'b1, pack_datetime(2020, 5, 5, 5, 60, 5));
        send_request(1'b1, pack_datetime(2020, 5, 5, 24, 5, 5));
        send_request(1'b1, pack_datetime(2020, 5, 0, 5, 5, 5));
        send_request(1'b1, pack_datetime(2020, 5, 32, 5, 5, 5));
        send_request(1'b1, pack_datetime(2020, 0, 5, 5, 5, 5));
        send_request(1'b1, pack_datetime(2020, 13, 5, 5, 5, 5));
        send_request(1'b1, pack_datetime(1999, 12, 31, 23, 59, 59));
        send_request(1'b1, pack_datetime(2101, 1, 1, 0, 0, 0));
        idle_line();
    endtask

    task automatic test_calendar_edges();
        send_request(1'b1, pack_datetime(2000, 1, 1, 0, 0, 0));
        send_request(1'b1, pack_datetime(2100, 12, 31, 23, 59, 59));
        send_request(1'b1, pack_datetime(2001, 2, 31, 12, 0, 0));
        send_request(1'b1, pack_datetime(2000, 2, 29, 0, 0, 0));
        send_request(1'b1, pack_datetime(2100, 2, 29, 0, 0, 0));
        send_request(1'b1, pack_datetime(2024, 4, 31, 1, 2, 3));
        send_request(1'b0, 47'd951782400);
        idle_line();
    endtask

    task automatic test_random_traffic();
        logic [46:0] v;
        int kind;
        for (int i = 0; i < 1500; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                send_request(1'b1, pack_datetime($urandom_range(2000, 2100),
                    $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(0, 23),
                    $urandom_range(0, 59), $urandom_range(0, 59)));
            else if (kind < 6)
                send_request(1'b0, 47'($urandom_range(1, 32'hFFFF_FFFF)));
            else
            begin
                v = {15'($urandom), $urandom};
                if (kind == 6)
                    v = v % 47'd100000000000000;
                send_request(kind[0], v);
            end
        end
        idle_line();
    endtask

    initial
    begin
        int wait_cycles;
        fail_count = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func  = 1'b0;
        value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_zero_and_extremes();
        test_field_errors();
        test_calendar_edges();
        test_random_traffic();
        wait_cycles = 0;
        while (pending_q.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (EPDC_LAT + 5) @(posedge clk);
        if (fail_count == 0 && pending_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
